// ===== hdl/rpn_pkg.sv =====
// Package for the reverse Polish expression evaluator.
// Holds data widths, stack depth default, character codes and operator codes.
// No dependencies; compiled before every other file of the block.
`default_nettype none

package rpn_pkg;

  // Value width and default stack depth
  localparam int DATA_W      = 32;
  localparam int CHAR_W      = 8;
  localparam int STACK_DEPTH = 16;

  typedef logic [DATA_W-1:0] data_t;
  typedef logic [CHAR_W-1:0] char_t;

  // Characters that carry meaning
  localparam char_t CH_PLUS  = 8'h2B; // '+'
  localparam char_t CH_MINUS = 8'h2D; // '-'
  localparam char_t CH_STAR  = 8'h2A; // '*'
  localparam char_t CH_SLASH = 8'h2F; // '/'
  localparam char_t CH_PCT   = 8'h25; // '%'
  localparam char_t CH_SPACE = 8'h20; // ' '
  localparam char_t CH_ZERO  = 8'h30; // '0'
  localparam char_t CH_NINE  = 8'h39; // '9'

  // Tokeniser phase
  typedef enum logic [1:0] {
    PH_FIRST = 2'd0,  // nothing seen yet but spaces
    PH_LIT   = 2'd1,  // inside a literal
    PH_OP    = 2'd2,  // just after an operator
    PH_SPACE = 2'd3   // after a separating space
  } phase_t;

  // Operator held while the operands are fetched
  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_MOD = 3'd4
  } op_t;

endpackage

`default_nettype wire

// ===== hdl/rpn_if.sv =====
// Valid/ready channel interfaces of the evaluator: characters in, results out.
// Depend on rpn_pkg for the payload types.
`default_nettype none

interface rpn_in_if;
  logic          valid;
  logic          ready;
  rpn_pkg::char_t char_code;
  logic          end_of_text;

  modport source (output valid, output char_code, output end_of_text, input ready);
  modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface

interface rpn_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [rpn_pkg::DATA_W-1:0] result_value;
  logic                              error;

  modport source (output valid, output result_value, output error, input ready);
  modport sink   (input valid, input result_value, input error, output ready);
endinterface

`default_nettype wire

// ===== hdl/rpn_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
`default_nettype none

module rpn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/rpn_div.sv =====
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on nothing but its parameter; used by the evaluator top level.
`default_nettype none

module rpn_div #(
  parameter int WIDTH = 32
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [WIDTH-1:0] dividend,
  input  wire logic [WIDTH-1:0] divisor,
  output logic                  done,
  output logic      [WIDTH-1:0] quotient,
  output logic      [WIDTH-1:0] remainder
);

  localparam int CNT_W = $clog2(WIDTH + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [WIDTH-1:0] quo_r, quo_nxt;
  logic [WIDTH-1:0] rem_r, rem_nxt;
  logic [WIDTH-1:0] dvs_r, dvs_nxt;
  logic [WIDTH:0]   trial;

  // One restoring step: shift in the next dividend bit, try the subtract
  assign trial = {rem_r, quo_r[WIDTH-1]} - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(WIDTH);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      if (!trial[WIDTH]) begin
        rem_nxt = trial[WIDTH-1:0];
        quo_nxt = {quo_r[WIDTH-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[WIDTH-2:0], quo_r[WIDTH-1]};
        quo_nxt = {quo_r[WIDTH-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

// ===== hdl/rpn_expression_evaluator.sv =====
// Reverse Polish expression evaluator: top level with value stack RAM and divider.
// Depends on rpn_pkg, rpn_if (channels), rpn_ram and rpn_div.
//
// Characters arrive one beat at a time on in_chan; a beat with end_of_text set
// closes the expression and yields one beat on out_chan carrying the value, or
// error with a zero value. Digits, spaces and characters that need no stack read
// are handled in S_IDLE. An operator passes through S_RD_B, S_RD_A, S_EXEC and
// S_WB: the two operands are read one after the other from the single read port
// of the stack RAM, then the result is written back. Division and modulo add S_DIV,
// which waits for the 32 steps of the bit-serial divider. The end beat goes to
// S_FIN, by S_FIN_RD when the value is read from the stack, and waits there for
// the previous result to be taken. The stack is a STACK_DEPTH-entry RAM; only
// entries below the fill count are ever read, so it needs no clearing after reset.
`default_nettype none

module rpn_expression_evaluator #(
  parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH
) (
  input wire logic  clk,
  input wire logic  rst_n,
  rpn_in_if.sink    in_chan,
  rpn_out_if.source out_chan
);

  localparam int ADDR_W = $clog2(STACK_DEPTH);
  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int DW     = rpn_pkg::DATA_W;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_RD_B   = 8'b0000_0010,
    S_RD_A   = 8'b0000_0100,
    S_EXEC   = 8'b0000_1000,
    S_DIV    = 8'b0001_0000,
    S_WB     = 8'b0010_0000,
    S_FIN_RD = 8'b0100_0000,
    S_FIN    = 8'b1000_0000
  } state_t;

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  rpn_pkg::data_t       acc_r, acc_nxt;
  rpn_pkg::phase_t      phase_r, phase_nxt;
  logic                 err_r, err_nxt;
  rpn_pkg::op_t         op_r, op_nxt;
  rpn_pkg::data_t       a_r, a_nxt;
  rpn_pkg::data_t       b_r, b_nxt;
  rpn_pkg::data_t       res_r, res_nxt;
  logic                 out_valid_r, out_valid_nxt;
  rpn_pkg::data_t       out_value_r, out_value_nxt;
  logic                 out_err_r, out_err_nxt;

  // Stack RAM and divider hookup
  logic                 mem_we, mem_re;
  logic [ADDR_W-1:0]    mem_waddr, mem_raddr;
  rpn_pkg::data_t       mem_wdata, mem_rdata;
  logic                 div_start, div_done;
  rpn_pkg::data_t       div_q, div_r;
  rpn_pkg::data_t       a_abs, b_abs;

  // Decode and helpers
  logic                 in_beat, out_free;
  logic                 is_digit, is_oper;
  rpn_pkg::op_t         char_op;
  rpn_pkg::data_t       acc_dig;
  logic [CNT_W-1:0]     cnt_m1, cnt_m2;

  rpn_ram #(
    .WIDTH (DW),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  rpn_div #(
    .WIDTH (DW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (a_abs),
    .divisor   (b_abs),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_beat       = in_chan.valid && in_chan.ready;
  assign out_free      = !out_valid_r || out_chan.ready;

  // Character classes
  assign is_digit = (in_chan.char_code >= rpn_pkg::CH_ZERO) &&
                    (in_chan.char_code <= rpn_pkg::CH_NINE);
  assign is_oper  = (in_chan.char_code == rpn_pkg::CH_PLUS)  ||
                    (in_chan.char_code == rpn_pkg::CH_MINUS) ||
                    (in_chan.char_code == rpn_pkg::CH_STAR)  ||
                    (in_chan.char_code == rpn_pkg::CH_SLASH) ||
                    (in_chan.char_code == rpn_pkg::CH_PCT);

  always_comb begin
    priority if (in_chan.char_code == rpn_pkg::CH_PLUS)  char_op = rpn_pkg::OP_ADD;
    else if     (in_chan.char_code == rpn_pkg::CH_MINUS) char_op = rpn_pkg::OP_SUB;
    else if     (in_chan.char_code == rpn_pkg::CH_STAR)  char_op = rpn_pkg::OP_MUL;
    else if     (in_chan.char_code == rpn_pkg::CH_SLASH) char_op = rpn_pkg::OP_DIV;
    else                                                 char_op = rpn_pkg::OP_MOD;
  end

  // acc * 10 + digit; a digit's low nibble is its value
  assign acc_dig = (acc_r << 3) + (acc_r << 1) + DW'(in_chan.char_code[3:0]);

  assign cnt_m1 = cnt_r - CNT_W'(1);
  assign cnt_m2 = cnt_r - CNT_W'(2);

  // Operand magnitudes for the divider
  assign a_abs = a_r[DW-1] ? (DW'(0) - a_r) : a_r;
  assign b_abs = b_r[DW-1] ? (DW'(0) - b_r) : b_r;

  // Sequencer. Reads and writes of the stack never overlap: each operator
  // finishes its write-back before the next beat is taken, so no forwarding.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    acc_nxt       = acc_r;
    phase_nxt     = phase_r;
    err_nxt       = err_r;
    op_nxt        = op_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_value_nxt = out_value_r;
    out_err_nxt   = out_err_r;
    mem_we        = 1'b0;
    mem_waddr     = cnt_r[ADDR_W-1:0];
    mem_wdata     = acc_r;
    mem_re        = 1'b0;
    mem_raddr     = cnt_m1[ADDR_W-1:0];
    div_start     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_beat && in_chan.end_of_text) begin
          // Close the expression: exactly one value must remain
          if (err_r || (phase_r == rpn_pkg::PH_FIRST) ||
              ((phase_r == rpn_pkg::PH_LIT) && (cnt_r != '0)) ||
              ((phase_r != rpn_pkg::PH_LIT) && (cnt_r != CNT_W'(1)))) begin
            err_nxt   = 1'b1;
            state_nxt = S_FIN;
          end else if (phase_r == rpn_pkg::PH_LIT) begin
            res_nxt   = acc_r;
            state_nxt = S_FIN;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = '0;
            state_nxt = S_FIN_RD;
          end
        end else if (in_beat && !err_r) begin
          if (in_chan.char_code == rpn_pkg::CH_SPACE) begin
            // Space ends a literal: push it
            if (phase_r == rpn_pkg::PH_LIT) begin
              if (cnt_r >= CNT_W'(STACK_DEPTH)) begin
                err_nxt = 1'b1;
              end else begin
                mem_we  = 1'b1;
                cnt_nxt = cnt_r + CNT_W'(1);
                acc_nxt = '0;
              end
            end
            if (phase_r != rpn_pkg::PH_FIRST) begin
              phase_nxt = rpn_pkg::PH_SPACE;
            end
          end else if (is_digit) begin
            if (phase_r == rpn_pkg::PH_OP) begin
              err_nxt = 1'b1;
            end else if (phase_r == rpn_pkg::PH_LIT) begin
              acc_nxt = acc_dig;
            end else begin
              acc_nxt   = DW'(in_chan.char_code[3:0]);
              phase_nxt = rpn_pkg::PH_LIT;
            end
          end else if (is_oper && (phase_r == rpn_pkg::PH_SPACE)) begin
            phase_nxt = rpn_pkg::PH_OP;
            op_nxt    = char_op;
            if (cnt_r < CNT_W'(2)) begin
              err_nxt = 1'b1;
            end else begin
              // Fetch b, the top entry
              mem_re    = 1'b1;
              state_nxt = S_RD_B;
            end
          end else begin
            err_nxt = 1'b1;
          end
        end
      end

      S_RD_B: begin
        b_nxt     = mem_rdata;
        mem_re    = 1'b1;
        mem_raddr = cnt_m2[ADDR_W-1:0];
        state_nxt = S_RD_A;
      end

      S_RD_A: begin
        a_nxt     = mem_rdata;
        state_nxt = S_EXEC;
      end

      S_EXEC: begin
        unique case (op_r)
          rpn_pkg::OP_ADD: begin
            res_nxt   = a_r + b_r;
            state_nxt = S_WB;
          end
          rpn_pkg::OP_SUB: begin
            res_nxt   = a_r - b_r;
            state_nxt = S_WB;
          end
          rpn_pkg::OP_MUL: begin
            res_nxt   = a_r * b_r;
            state_nxt = S_WB;
          end
          rpn_pkg::OP_DIV, rpn_pkg::OP_MOD: begin
            if (b_r == '0) begin
              err_nxt   = 1'b1;
              state_nxt = S_IDLE;
            end else begin
              div_start = 1'b1;
              state_nxt = S_DIV;
            end
          end
          default: begin
            err_nxt   = 1'b1;
            state_nxt = S_IDLE;
          end
        endcase
      end

      S_DIV: begin
        // Signs: quotient negative when signs differ, remainder follows a
        if (div_done) begin
          if (op_r == rpn_pkg::OP_DIV) begin
            res_nxt = (a_r[DW-1] ^ b_r[DW-1]) ? (DW'(0) - div_q) : div_q;
          end else begin
            res_nxt = a_r[DW-1] ? (DW'(0) - div_r) : div_r;
          end
          state_nxt = S_WB;
        end
      end

      S_WB: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_m2[ADDR_W-1:0];
        mem_wdata = res_r;
        cnt_nxt   = cnt_m1;
        state_nxt = S_IDLE;
      end

      S_FIN_RD: begin
        res_nxt   = mem_rdata;
        state_nxt = S_FIN;
      end

      S_FIN: begin
        // Hand over to the output register, then start afresh
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = err_r ? '0 : res_r;
          out_err_nxt   = err_r;
          cnt_nxt       = '0;
          acc_nxt       = '0;
          phase_nxt     = rpn_pkg::PH_FIRST;
          err_nxt       = 1'b0;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      acc_r       <= '0;
      phase_r     <= rpn_pkg::PH_FIRST;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      acc_r       <= acc_nxt;
      phase_r     <= phase_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r        <= op_nxt;
    a_r         <= a_nxt;
    b_r         <= b_nxt;
    res_r       <= res_nxt;
    out_value_r <= out_value_nxt;
    out_err_r   <= out_err_nxt;
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.result_value = $signed(out_value_r);
  assign out_chan.error        = out_err_r;

  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_exec_operands: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) |-> (cnt_r >= CNT_W'(2)))
    else $error("operator executing with fewer than two values");

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider finished outside divide wait");

  a_write_slot: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> ((state_r == S_IDLE) || (state_r == S_WB)))
    else $error("stack write outside push or write-back");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result raised without closing an expression");

endmodule

`default_nettype wire
